### hdl/defd_pkg.sv
// Shared types and constants for the dirty entry flush decider.
`timescale 1ns / 1ps

package defd_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int AGE_W     = 32;
  localparam int CMD_W     = 3;
  localparam int KEY_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int LIST_MAX  = 16;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK      = 3'd0,
    CMD_MARK      = 3'd1,
    CMD_CLEAR     = 3'd2,
    CMD_CLEAR_ALL = 3'd3,
    CMD_LIST      = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_DIRTY_COUNT = 2'd0,
    REG_DEBOUNCE_ENABLE = 2'd1,
    REG_DEBOUNCE_MS     = 2'd2
  } cfg_reg_t;

  localparam logic [4:0]       MAX_DIRTY_RST = 5'd8;
  localparam logic             DEB_EN_RST    = 1'b0;
  localparam logic [AGE_W-1:0] DEB_MS_RST    = 32'd1000;

  // Control from the sequencer to the age unit.
  typedef struct packed {
    logic walk_en;
    logic walk_dirty;
    logic tick;
    logic zero_en;
  } age_ctl_t;

  // Per-slot verdict coming back from the age unit.
  typedef struct packed {
    logic vld;
    logic aged;
  } age_res_t;

endpackage

### hdl/defd_age_unit.sv
// Age memory with the shared saturating incrementer and debounce comparator.
`timescale 1ns / 1ps

module defd_age_unit #(
  parameter int SLOTS = defd_pkg::SLOTS_DEF,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  defd_pkg::age_ctl_t          ctl,
  input  logic [IDX_W-1:0]            walk_idx,
  input  logic [IDX_W-1:0]            zero_idx,
  input  logic [defd_pkg::AGE_W-1:0]  debounce_ms,
  output defd_pkg::age_res_t          res
);

  logic [defd_pkg::AGE_W-1:0] mem [SLOTS];
  logic [defd_pkg::AGE_W-1:0] rd_age;
  logic [defd_pkg::AGE_W-1:0] age_new;
  logic [IDX_W-1:0]           rd_idx;
  logic                       rd_vld;
  logic                       rd_dirty;
  logic                       rd_tick;
  logic                       bump;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= ctl.walk_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_age   <= mem[walk_idx];
    rd_idx   <= walk_idx;
    rd_dirty <= ctl.walk_dirty;
    rd_tick  <= ctl.tick;
  end

  // A slot that is not dirty never ages, and its stored age is not looked at
  // until a mark has written zero to it.
  assign bump    = rd_vld && rd_tick && rd_dirty && (rd_age != defd_pkg::AGE_MAX);
  assign age_new = bump ? rd_age + 1'b1 : rd_age;

  always_ff @(posedge clk) begin
    if (ctl.zero_en) begin
      mem[zero_idx] <= '0;
    end else if (bump) begin
      mem[rd_idx] <= age_new;
    end
  end

  assign res.vld  = rd_vld;
  assign res.aged = rd_dirty && (age_new >= debounce_ms);

endmodule

### hdl/dirty_entry_flush_decider.sv
// Top level of the dirty entry flush decider: slot flags, sequencer and ports.
`timescale 1ns / 1ps

// Timing: after the input transfer the sequencer walks every slot in turn through the one
// age incrementer and comparator, takes the last verdict in S_DRAIN and loads the result
// in S_EMIT. In a list run, the dirty slots' results are loaded in ascending slot order.
// A new command is taken only once the last result of the previous one is loaded, so list
// results and output stalls hold the input. Reset (rst, synchronous) empties the table
// and restores the registers; a mark zeroes a slot's age first.
module dirty_entry_flush_decider #(
  parameter int SLOTS = defd_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream. tdata from bit 0: cmd[2:0], key_index[6:3], zero pad [7].
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,
  // Result stream. tdata from bit 0: key_dirty[0], flush_needed[1],
  // listed_valid[2], listed_slot[6:3], zero pad [7]. tlast marks the end.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,
  output logic                            m_tlast,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [defd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [defd_pkg::CFG_W-1:0]      cfg_data
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;
  localparam int LIST_N = (SLOTS < defd_pkg::LIST_MAX) ? SLOTS : defd_pkg::LIST_MAX;
  localparam int LIDX_W = (LIST_N > 1) ? $clog2(LIST_N) : 1;
  localparam logic [IDX_W-1:0] WALK_LAST = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [4:0]                 max_dirty_count;
  logic                       debounce_enable;
  logic [defd_pkg::AGE_W-1:0] debounce_ms;

  // Slot flags live in flip-flops; the ages live in the age unit's memory.
  logic [SLOTS-1:0] present;
  logic [SLOTS-1:0] dirty;

  // The command in progress.
  defd_pkg::cmd_t cmd_q;
  logic [IDX_W-1:0] kidx_q;
  logic             key_ok_q;

  // Walk and decision state.
  logic [IDX_W-1:0]  wptr;
  logic [CNT_W-1:0]  cnt;
  logic              aged_acc;
  logic              flush;
  logic              list_any;
  logic [LIDX_W-1:0] lptr;

  // Output register.
  logic       o_kd;
  logic       o_fl;
  logic       o_lv;
  logic [3:0] o_ls;

  // Input decode.
  logic                      acc;
  defd_pkg::cmd_t            in_cmd;
  logic [defd_pkg::KEY_W-1:0] in_key;
  logic [IDX_W-1:0]          in_kidx;
  logic                      in_key_ok;

  defd_pkg::age_ctl_t age_ctl;
  defd_pkg::age_res_t age_res;

  logic              out_free;
  logic              load_out;
  logic [LIST_N-1:0] ldv;
  logic              more_above;
  logic              kd;
  logic              aged_final;

  assign s_tready  = (state == S_IDLE);
  assign acc       = s_tvalid && s_tready;
  assign in_cmd    = defd_pkg::cmd_t'(s_tdata[2:0]);
  assign in_key    = s_tdata[6:3];
  assign in_kidx   = IDX_W'(in_key);
  assign in_key_ok = (32'(in_key) < 32'(SLOTS));

  assign age_ctl.walk_en    = (state == S_WALK);
  assign age_ctl.walk_dirty = dirty[wptr];
  assign age_ctl.tick       = (cmd_q == defd_pkg::CMD_TICK);
  assign age_ctl.zero_en    = acc && (in_cmd == defd_pkg::CMD_MARK) && in_key_ok;

  defd_age_unit #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_age (
    .clk         (clk),
    .rst         (rst),
    .ctl         (age_ctl),
    .walk_idx    (wptr),
    .zero_idx    (in_kidx),
    .debounce_ms (debounce_ms),
    .res         (age_res)
  );

  assign out_free   = !m_tvalid || m_tready;
  // Only slots 0 to 15 can be addressed, so only those appear in a list run.
  assign ldv        = dirty[LIST_N-1:0];
  assign more_above = |((ldv >> lptr) >> 1);
  assign kd         = key_ok_q && dirty[kidx_q];
  assign aged_final = aged_acc || (age_res.vld && age_res.aged);

  // High in the cycle in which a new result is loaded into the output register.
  assign load_out = (state == S_EMIT) && out_free &&
                    ((cmd_q != defd_pkg::CMD_LIST) || !list_any || ldv[lptr]);

  assign m_tdata = {1'b0, o_ls, o_lv, o_fl, o_kd};

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      present         <= '0;
      dirty           <= '0;
      m_tvalid        <= 1'b0;
      max_dirty_count <= defd_pkg::MAX_DIRTY_RST;
      debounce_enable <= defd_pkg::DEB_EN_RST;
      debounce_ms     <= defd_pkg::DEB_MS_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          defd_pkg::REG_MAX_DIRTY_COUNT: max_dirty_count <= cfg_data[4:0];
          defd_pkg::REG_DEBOUNCE_ENABLE: debounce_enable <= cfg_data[0];
          defd_pkg::REG_DEBOUNCE_MS:     debounce_ms     <= cfg_data;
          default: ;
        endcase
      end

      if (m_tready && !load_out) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (acc) begin
            cmd_q    <= in_cmd;
            kidx_q   <= in_kidx;
            key_ok_q <= in_key_ok;
            case (in_cmd)
              defd_pkg::CMD_MARK: begin
                if (in_key_ok) begin
                  present[in_kidx] <= 1'b1;
                  dirty[in_kidx]   <= 1'b1;
                end
              end
              defd_pkg::CMD_CLEAR: begin
                // Clearing a slot that is not present has no effect.
                if (in_key_ok && present[in_kidx]) begin
                  dirty[in_kidx] <= 1'b0;
                end
              end
              defd_pkg::CMD_CLEAR_ALL: begin
                present <= '0;
                dirty   <= '0;
              end
              default: ;
            endcase
            wptr     <= '0;
            cnt      <= '0;
            aged_acc <= 1'b0;
            state    <= S_WALK;
          end
        end

        S_WALK: begin
          // One slot read per cycle; its verdict arrives in the cycle after.
          cnt <= cnt + CNT_W'(dirty[wptr]);
          if (age_res.vld) begin
            aged_acc <= aged_acc || age_res.aged;
          end
          if (wptr == WALK_LAST) begin
            state <= S_DRAIN;
          end else begin
            wptr <= wptr + 1'b1;
          end
        end

        S_DRAIN: begin
          // The last slot's verdict is on the bus now.
          flush <= (|present) &&
                   ((CMP_W'(cnt) >= CMP_W'(max_dirty_count)) ||
                    (debounce_enable && aged_final));
          list_any <= |ldv;
          lptr     <= '0;
          state    <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            if ((cmd_q != defd_pkg::CMD_LIST) || !list_any) begin
              m_tvalid <= 1'b1;
              o_kd     <= kd;
              o_fl     <= flush;
              o_lv     <= 1'b0;
              o_ls     <= '0;
              m_tlast  <= 1'b1;
              state    <= S_IDLE;
            end else if (ldv[lptr]) begin
              m_tvalid <= 1'b1;
              o_kd     <= kd;
              o_fl     <= flush;
              o_lv     <= 1'b1;
              o_ls     <= 4'(lptr);
              m_tlast  <= !more_above;
              if (!more_above) begin
                state <= S_IDLE;
              end else begin
                lptr <= lptr + 1'b1;
              end
            end else begin
              lptr <= lptr + 1'b1;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/defd_checker.sv
// Port-level checks for the dirty entry flush decider, bound to the top level.
`timescale 1ns / 1ps

module defd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // After reset the block takes input and shows no result.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (s_tready && !m_tvalid))
    else $error("block not idle after reset");

  // A command keeps the block busy for its whole walk.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again right after a transfer");

  // A result that is not the last of its command is always a listed slot.
  a_mid_run_listed: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> m_tdata[2])
    else $error("non-final result without a listed slot");

  // A result without a listed slot carries slot zero.
  a_unlisted_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[2]) |-> (m_tdata[6:3] == 4'd0))
    else $error("unlisted result carries a slot index");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind dirty_entry_flush_decider defd_checker u_defd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
